// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL top level. Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TOVC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TOVC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TOVC_ASSERT_IMPLY(lbl, ante, cons)
`define TOVC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/tovc_pkg.sv =====
// ----------------------------------------------------------------------------
// tovc_pkg
// Types and codes shared by the tank overflow valve controller modules.
// ----------------------------------------------------------------------------
package tovc_pkg;

  localparam int unsigned LevelW   = 10;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned PatW     = 2;

  // Machine states.
  localparam logic [ModeW-1:0] ModeOk         = 3'd0;
  localparam logic [ModeW-1:0] ModeOverStart  = 3'd1;
  localparam logic [ModeW-1:0] ModeOverWait   = 3'd2;
  localparam logic [ModeW-1:0] ModeRecover    = 3'd3;
  localparam logic [ModeW-1:0] ModeHandStart  = 3'd4;
  localparam logic [ModeW-1:0] ModeHandWait   = 3'd5;
  localparam logic [ModeW-1:0] ModeHandOver   = 3'd6;

  // LED strip patterns.
  localparam logic [PatW-1:0] PatLevel   = 2'd0;
  localparam logic [PatW-1:0] PatRainbow = 2'd1;
  localparam logic [PatW-1:0] PatSpinner = 2'd2;
  localparam logic [PatW-1:0] PatWarning = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgMaxLevel   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgHyst       = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgHandHyst   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgAbsMax     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTimeout    = 3'd4;

  // Item kinds.
  localparam logic KindPoll   = 1'b0;
  localparam logic KindManual = 1'b1;

  typedef struct packed {
    logic [LevelW-1:0] max_level;
    logic [LevelW-1:0] hysteresis;
    logic [LevelW-1:0] hand_hysteresis;
    logic [LevelW-1:0] absolute_max;
    logic [CountW-1:0] timeout_polls;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic [LevelW-1:0] level;
    logic              button_pressed;
    logic              manual_value;
  } item_t;

  typedef struct packed {
    logic             valve_on;
    logic             switch_led_on;
    logic [PatW-1:0]  led_pattern;
    logic [ModeW-1:0] mode;
    logic             manual_flag;
  } result_t;

endpackage

// ===== rtl/core/tovc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tovc_cfg_regs
// Configuration register file with reset defaults; writes are registered.
// ----------------------------------------------------------------------------
module tovc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [tovc_pkg::CfgIdxW-1:0]  idx_i,
  input  logic [tovc_pkg::CfgDataW-1:0] data_i,
  output tovc_pkg::cfg_t                cfg_o
);

  tovc_pkg::cfg_t cfg_q;
  tovc_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        tovc_pkg::CfgMaxLevel: cfg_d.max_level       = data_i[tovc_pkg::LevelW-1:0];
        tovc_pkg::CfgHyst:     cfg_d.hysteresis      = data_i[tovc_pkg::LevelW-1:0];
        tovc_pkg::CfgHandHyst: cfg_d.hand_hysteresis = data_i[tovc_pkg::LevelW-1:0];
        tovc_pkg::CfgAbsMax:   cfg_d.absolute_max    = data_i[tovc_pkg::LevelW-1:0];
        tovc_pkg::CfgTimeout:  cfg_d.timeout_polls   = data_i[tovc_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_level       <= 10'd900;
      cfg_q.hysteresis      <= 10'd50;
      cfg_q.hand_hysteresis <= 10'd30;
      cfg_q.absolute_max    <= 10'd980;
      cfg_q.timeout_polls   <= 16'd1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/tovc_fsm.sv =====
// ----------------------------------------------------------------------------
// tovc_fsm
// Valve state machine: state registers and the one-step update per item.
// ----------------------------------------------------------------------------
module tovc_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tovc_pkg::cfg_t      cfg_i,
  input  logic                step_i,
  input  tovc_pkg::item_t     item_i,
  output tovc_pkg::result_t   res_o
);

  logic [tovc_pkg::ModeW-1:0]  mode_q, mode_d;
  logic                        valve_q, valve_d;
  logic                        manual_q, manual_d;
  logic                        swled_q, swled_d;
  logic [tovc_pkg::PatW-1:0]   pat_q, pat_d;
  logic [tovc_pkg::LevelW-1:0] start_q, start_d;
  logic [tovc_pkg::CountW-1:0] elapsed_q, elapsed_d;

  logic [tovc_pkg::LevelW:0] lvl_plus_hyst;
  logic [tovc_pkg::LevelW:0] lvl_plus_hhyst;
  logic [tovc_pkg::LevelW:0] start_plus_hhyst;
  logic                      timed_out;

  // Signed threshold compares are done as unsigned sums on the other side.
  assign lvl_plus_hyst    = {1'b0, item_i.level} + {1'b0, cfg_i.hysteresis};
  assign lvl_plus_hhyst   = {1'b0, item_i.level} + {1'b0, cfg_i.hand_hysteresis};
  assign start_plus_hhyst = {1'b0, start_q} + {1'b0, cfg_i.hand_hysteresis};
  assign timed_out        = (elapsed_q >= cfg_i.timeout_polls);

  always_comb begin
    mode_d    = mode_q;
    valve_d   = valve_q;
    manual_d  = manual_q;
    swled_d   = swled_q;
    pat_d     = pat_q;
    start_d   = start_q;
    elapsed_d = elapsed_q;
    if (item_i.kind == tovc_pkg::KindManual) begin
      manual_d = item_i.manual_value;
    end else begin
      case (mode_q)
        tovc_pkg::ModeOk: begin
          if (item_i.level > cfg_i.max_level) mode_d = tovc_pkg::ModeOverStart;
        end
        tovc_pkg::ModeOverStart: begin
          valve_d = 1'b0;
          swled_d = 1'b1;
          pat_d   = tovc_pkg::PatRainbow;
          mode_d  = tovc_pkg::ModeOverWait;
        end
        tovc_pkg::ModeOverWait: begin
          if (lvl_plus_hyst < {1'b0, cfg_i.max_level}) mode_d = tovc_pkg::ModeRecover;
          if (item_i.button_pressed || manual_q) mode_d = tovc_pkg::ModeHandStart;
        end
        tovc_pkg::ModeRecover: begin
          valve_d  = 1'b1;
          swled_d  = 1'b0;
          pat_d    = tovc_pkg::PatLevel;
          manual_d = 1'b0;
          mode_d   = tovc_pkg::ModeOk;
        end
        tovc_pkg::ModeHandStart: begin
          pat_d     = tovc_pkg::PatSpinner;
          swled_d   = 1'b0;
          valve_d   = 1'b1;
          start_d   = item_i.level;
          elapsed_d = '0;
          mode_d    = tovc_pkg::ModeHandWait;
        end
        tovc_pkg::ModeHandWait: begin
          // Later checks override earlier ones: fall-back beats overflow.
          if (({1'b0, item_i.level} > start_plus_hhyst) ||
              (item_i.level > cfg_i.absolute_max)) begin
            mode_d = tovc_pkg::ModeHandOver;
          end
          if (!manual_q && valve_q) mode_d = tovc_pkg::ModeOverStart;
          if (!timed_out) elapsed_d = elapsed_q + 1'b1;
          if (timed_out || (lvl_plus_hhyst < {1'b0, cfg_i.max_level})) begin
            mode_d = tovc_pkg::ModeOverStart;
          end
        end
        tovc_pkg::ModeHandOver: begin
          swled_d  = 1'b1;
          valve_d  = 1'b0;
          pat_d    = tovc_pkg::PatWarning;
          manual_d = 1'b0;
          mode_d   = tovc_pkg::ModeOverWait;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= tovc_pkg::ModeRecover;
      valve_q   <= 1'b0;
      manual_q  <= 1'b0;
      swled_q   <= 1'b0;
      pat_q     <= tovc_pkg::PatLevel;
      start_q   <= '0;
      elapsed_q <= '0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      valve_q   <= valve_d;
      manual_q  <= manual_d;
      swled_q   <= swled_d;
      pat_q     <= pat_d;
      start_q   <= start_d;
      elapsed_q <= elapsed_d;
    end
  end

  // The result reports the state after the item.
  assign res_o.valve_on      = valve_d;
  assign res_o.switch_led_on = swled_d;
  assign res_o.led_pattern   = pat_d;
  assign res_o.mode          = mode_d;
  assign res_o.manual_flag   = manual_d;

endmodule

// ===== rtl/core/tank_overflow_valve_controller.sv =====
// ----------------------------------------------------------------------------
// tank_overflow_valve_controller
// Input register, one-step valve state machine and a result register.
// ----------------------------------------------------------------------------
// A word waits in the input register until the result register is free.
// Throughput: one word per cycle while out_ready_i is high; the two registers
// form a two-deep pipeline, so one new word is taken while a result waits.
// Reset (rst_ni low, asynchronous) clears both stages, loads the register
// defaults and puts the machine in the recover state with the valve closed.
module tank_overflow_valve_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tovc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tovc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_kind_i,
  input  logic [tovc_pkg::LevelW-1:0]   in_level_i,
  input  logic                          in_button_pressed_i,
  input  logic                          in_manual_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_valve_on_o,
  output logic                          out_switch_led_on_o,
  output logic [tovc_pkg::PatW-1:0]     out_led_pattern_o,
  output logic [tovc_pkg::ModeW-1:0]    out_mode_o,
  output logic                          out_manual_flag_o
);

  tovc_pkg::cfg_t    cfg;
  tovc_pkg::item_t   item_q;
  tovc_pkg::result_t res_next;
  tovc_pkg::result_t res_q;
  logic              item_valid_q;
  logic              out_valid_q;
  logic              step;
  logic              in_fire;

  tovc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // The item in the input register steps the machine when the result
  // register is free or being emptied in this cycle.
  assign step       = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || step;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.kind           <= in_kind_i;
      item_q.level          <= in_level_i;
      item_q.button_pressed <= in_button_pressed_i;
      item_q.manual_value   <= in_manual_value_i;
    end
  end

  tovc_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .item_i (item_q),
    .res_o  (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_next;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_valve_on_o      = res_q.valve_on;
  assign out_switch_led_on_o = res_q.switch_led_on;
  assign out_led_pattern_o   = res_q.led_pattern;
  assign out_mode_o          = res_q.mode;
  assign out_manual_flag_o   = res_q.manual_flag;

`include "assert_macros.svh"

  // The valve is always closed while waiting out an overfill.
  `TOVC_ASSERT_IMPLY(a_overwait_closed, out_valid_o && (out_mode_o == tovc_pkg::ModeOverWait), !out_valve_on_o)
  // Hand filling runs with the valve open and the spinner pattern.
  `TOVC_ASSERT_IMPLY(a_handwait_open, out_valid_o && (out_mode_o == tovc_pkg::ModeHandWait), out_valve_on_o && (out_led_pattern_o == tovc_pkg::PatSpinner))
  // An empty result register never blocks the input side.
  `TOVC_ASSERT_IMPLY(a_ready_when_empty, !out_valid_o, in_ready_o)
  // A stepped item always produces a result in the next cycle.
  `TOVC_ASSERT_NEXT(a_step_gives_result, step, out_valid_o)

endmodule

// ===== tb/sv/tank_overflow_valve_controller_tb.sv =====
// ----------------------------------------------------------------------------
// tank_overflow_valve_controller_tb
// Self-checking bench for the tank overflow valve controller. A short table
// of directed words walks the valve machine through its paths at the reset
// settings. Several phases of random words follow, each under its own
// register settings. A word-by-word model of the machine predicts every
// status word, and each output word is compared field by field in order.
// ----------------------------------------------------------------------------
module tank_overflow_valve_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tovc_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned WordsPerPass = 255;
  localparam int unsigned NumPasses    = 7;
  localparam int unsigned NumDirected  = 25;

  typedef struct packed {
    item_t   word;
    logic    typed;
    result_t want;
  } dir_row_t;

  localparam result_t NoCheck = '0;

  // Rows with a typed status follow directly from the reset settings; the
  // rest are checked against the machine model.
  localparam dir_row_t DirRows [NumDirected] = '{
    '{'{KindManual, 10'd0,    1'b0, 1'b1}, 1'b1, '{1'b0, 1'b0, PatLevel, ModeRecover, 1'b1}},
    '{'{KindPoll,   10'd0,    1'b1, 1'b0}, 1'b1, '{1'b1, 1'b0, PatLevel, ModeOk, 1'b0}},
    '{'{KindPoll,   10'd900,  1'b1, 1'b0}, 1'b1, '{1'b1, 1'b0, PatLevel, ModeOk, 1'b0}},
    '{'{KindPoll,   10'd1023, 1'b0, 1'b0}, 1'b1, '{1'b1, 1'b0, PatLevel, ModeOverStart, 1'b0}},
    '{'{KindPoll,   10'd0,    1'b0, 1'b0}, 1'b1, '{1'b0, 1'b1, PatRainbow, ModeOverWait, 1'b0}},
    '{'{KindPoll,   10'd850,  1'b0, 1'b1}, 1'b0, NoCheck},
    '{'{KindPoll,   10'd849,  1'b0, 1'b0}, 1'b0, NoCheck},
    '{'{KindPoll,   10'd0,    1'b0, 1'b0}, 1'b0, NoCheck},
    '{'{KindPoll,   10'd901,  1'b0, 1'b0}, 1'b0, NoCheck},
    '{'{KindPoll,   10'd901,  1'b0, 1'b0}, 1'b0, NoCheck},
    '{'{KindManual, 10'd1023, 1'b1, 1'b1}, 1'b0, NoCheck},
    '{'{KindPoll,   10'd960,  1'b0, 1'b0}, 1'b0, NoCheck},
    '{'{KindPoll,   10'd960,  1'b0, 1'b0}, 1'b0, NoCheck},
    '{'{KindPoll,   10'd990,  1'b0, 1'b0}, 1'b0, NoCheck},
    '{'{KindPoll,   10'd990,  1'b0, 1'b0}, 1'b0, NoCheck},
    '{'{KindPoll,   10'd1023, 1'b1, 1'b0}, 1'b0, NoCheck},
    '{'{KindPoll,   10'd900,  1'b0, 1'b0}, 1'b0, NoCheck},
    '{'{KindPoll,   10'd931,  1'b0, 1'b0}, 1'b0, NoCheck},
    '{'{KindManual, 10'd0,    1'b0, 1'b1}, 1'b0, NoCheck},
    '{'{KindPoll,   10'd900,  1'b0, 1'b0}, 1'b0, NoCheck},
    '{'{KindPoll,   10'd900,  1'b0, 1'b0}, 1'b0, NoCheck},
    '{'{KindPoll,   10'd900,  1'b0, 1'b0}, 1'b0, NoCheck},
    '{'{KindPoll,   10'd869,  1'b0, 1'b0}, 1'b0, NoCheck},
    '{'{KindManual, 10'd0,    1'b1, 1'b0}, 1'b0, NoCheck},
    '{'{KindPoll,   10'd1023, 1'b0, 1'b0}, 1'b0, NoCheck}
  };

  logic                clk_i               = 1'b0;
  logic                rst_ni              = 1'b0;
  logic                cfg_we_i            = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i           = '0;
  logic [CfgDataW-1:0] cfg_data_i          = '0;
  logic                in_valid_i          = 1'b0;
  logic                in_kind_i           = 1'b0;
  logic [LevelW-1:0]   in_level_i          = '0;
  logic                in_button_pressed_i = 1'b0;
  logic                in_manual_value_i   = 1'b0;
  logic                out_ready_i         = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic                out_valve_on_o;
  logic                out_switch_led_on_o;
  logic [PatW-1:0]     out_led_pattern_o;
  logic [ModeW-1:0]    out_mode_o;
  logic                out_manual_flag_o;

  tank_overflow_valve_controller uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .in_kind_i           (in_kind_i),
    .in_level_i          (in_level_i),
    .in_button_pressed_i (in_button_pressed_i),
    .in_manual_value_i   (in_manual_value_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .out_valve_on_o      (out_valve_on_o),
    .out_switch_led_on_o (out_switch_led_on_o),
    .out_led_pattern_o   (out_led_pattern_o),
    .out_mode_o          (out_mode_o),
    .out_manual_flag_o   (out_manual_flag_o)
  );

  always #4 clk_i = ~clk_i;

  // Model of the valve machine: settings and state.
  cfg_t             valve_cfg;
  logic [ModeW-1:0] m_mode;
  logic             m_valve;
  logic             m_manual;
  logic             m_switch_led;
  logic [PatW-1:0]  m_pattern;
  logic [LevelW-1:0] m_hand_base;
  logic [CountW-1:0] m_hand_polls;

  result_t pending_status [$];
  int      fault_count = 0;
  bit      calm_stretch = 1'b0;
  bit      long_hold_req = 1'b0;

  function automatic result_t predict_status(input item_t w);
    int      lvl;
    int      mx;
    bit      timed_out;
    result_t r;
    lvl = int'(w.level);
    mx  = int'(valve_cfg.max_level);
    if (w.kind == KindManual) begin
      m_manual = w.manual_value;
    end else begin
      case (m_mode)
        ModeOk: begin
          if (w.level > valve_cfg.max_level) m_mode = ModeOverStart;
        end
        ModeOverStart: begin
          m_valve      = 1'b0;
          m_switch_led = 1'b1;
          m_pattern    = PatRainbow;
          m_mode       = ModeOverWait;
        end
        ModeOverWait: begin
          if (lvl < mx - int'(valve_cfg.hysteresis)) m_mode = ModeRecover;
          if (w.button_pressed || m_manual) m_mode = ModeHandStart;
        end
        ModeRecover: begin
          m_valve      = 1'b1;
          m_switch_led = 1'b0;
          m_pattern    = PatLevel;
          m_manual     = 1'b0;
          m_mode       = ModeOk;
        end
        ModeHandStart: begin
          m_pattern    = PatSpinner;
          m_switch_led = 1'b0;
          m_valve      = 1'b1;
          m_hand_base  = w.level;
          m_hand_polls = '0;
          m_mode       = ModeHandWait;
        end
        ModeHandWait: begin
          // The fall-back checks come last so that they override overflow.
          if (lvl - int'(m_hand_base) > int'(valve_cfg.hand_hysteresis) ||
              w.level > valve_cfg.absolute_max) m_mode = ModeHandOver;
          if (!m_manual && m_valve) m_mode = ModeOverStart;
          timed_out = (m_hand_polls >= valve_cfg.timeout_polls);
          if (!timed_out) m_hand_polls = m_hand_polls + 1'b1;
          if (timed_out || lvl < mx - int'(valve_cfg.hand_hysteresis))
            m_mode = ModeOverStart;
        end
        ModeHandOver: begin
          m_switch_led = 1'b1;
          m_valve      = 1'b0;
          m_pattern    = PatWarning;
          m_manual     = 1'b0;
          m_mode       = ModeOverWait;
        end
        default: ;
      endcase
    end
    r.valve_on      = m_valve;
    r.switch_led_on = m_switch_led;
    r.led_pattern   = m_pattern;
    r.mode          = m_mode;
    r.manual_flag   = m_manual;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    if (r < 98) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  // Levels mostly cluster around the thresholds that the machine compares
  // against, so that the hand-mode paths are reached often.
  function automatic item_t pick_word();
    item_t w;
    int    piv;
    w.kind = ($urandom_range(0, 99) < 12) ? KindManual : KindPoll;
    if (w.kind == KindManual) w.manual_value = ($urandom_range(0, 99) < 75);
    else w.manual_value = 1'($urandom_range(0, 1));
    w.button_pressed = ($urandom_range(0, 99) < 20);
    case ($urandom_range(0, 7))
      0: piv = int'(valve_cfg.max_level);
      1: piv = int'(valve_cfg.max_level) - int'(valve_cfg.hysteresis);
      2: piv = int'(valve_cfg.max_level) - int'(valve_cfg.hand_hysteresis);
      3: piv = int'(valve_cfg.absolute_max);
      4: piv = int'(m_hand_base) + int'(valve_cfg.hand_hysteresis);
      5: piv = int'(m_hand_base);
      6: piv = int'($urandom_range(0, 1023));
      default: piv = $urandom_range(0, 1) ? 1023 : 0;
    endcase
    piv = piv + int'($urandom_range(0, 6)) - 3;
    if (piv < 0) piv = 0;
    if (piv > 1023) piv = 1023;
    w.level = piv[LevelW-1:0];
    return w;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input cfg_t c);
    write_reg(CfgMaxLevel, CfgDataW'(c.max_level));
    write_reg(CfgHyst,     CfgDataW'(c.hysteresis));
    write_reg(CfgHandHyst, CfgDataW'(c.hand_hysteresis));
    write_reg(CfgAbsMax,   CfgDataW'(c.absolute_max));
    write_reg(CfgTimeout,  c.timeout_polls);
    cfg_we_i  <= 1'b0;
    valve_cfg = c;
    @(posedge clk_i);
  endtask

  task automatic offer_word(input item_t w, input bit typed, input result_t want);
    int      gap;
    result_t predicted;
    gap = calm_stretch ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    in_kind_i           <= w.kind;
    in_level_i          <= w.level;
    in_button_pressed_i <= w.button_pressed;
    in_manual_value_i   <= w.manual_value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = predict_status(w);
    pending_status.push_back(typed ? want : predicted);
  endtask

  task automatic drain();
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic cfg_t pass_settings(input int unsigned pass);
    cfg_t c;
    c.max_level       = LevelW'($urandom_range(0, 1023));
    c.hysteresis      = LevelW'($urandom_range(0, 1023));
    c.hand_hysteresis = LevelW'($urandom_range(0, 1023));
    c.absolute_max    = LevelW'($urandom_range(0, 1023));
    c.timeout_polls   = CountW'($urandom_range(1, 65535));
    case (pass)
      0: c = '{10'd900, 10'd50, 10'd30, 10'd980, 16'd1000};
      1: c = '{10'd0, 10'd0, 10'd0, 10'd0, 16'd1};
      2: c = '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 16'd65535};
      // Both thresholds below zero.
      3: c = '{10'd10, 10'd1023, 10'd1023, 10'd500, 16'd3};
      4: c.timeout_polls = CountW'($urandom_range(1, 8));
      // A zero timeout ends hand mode on its first wait poll.
      5: c = '{10'd600, 10'd40, 10'd20, 10'd700, 16'd0};
      default: if ($urandom_range(0, 1)) c.timeout_polls = CountW'($urandom_range(1, 20));
    endcase
    return c;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fault_count++;
    end
  endfunction

  // Output side: check accepted words and stall at random.
  initial begin
    int      stall_left;
    int      g;
    result_t e;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_status.size() == 0) begin
          $display("%0t: status word with nothing expected, actual mode %0d", $time,
                   out_mode_o);
          fault_count++;
        end else begin
          e = pending_status.pop_front();
          check_field("valve_on", int'(e.valve_on), int'(out_valve_on_o));
          check_field("switch_led_on", int'(e.switch_led_on), int'(out_switch_led_on_o));
          check_field("led_pattern", int'(e.led_pattern), int'(out_led_pattern_o));
          check_field("mode", int'(e.mode), int'(out_mode_o));
          check_field("manual_flag", int'(e.manual_flag), int'(out_manual_flag_o));
        end
      end
      if (long_hold_req) begin
        // Long hold-off so that the pipeline fills and stalls the input.
        long_hold_req = 1'b0;
        stall_left    = 300;
        out_ready_i  <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (calm_stretch) begin
        out_ready_i <= 1'b1;
      end else begin
        g = idle_len();
        if (g == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          stall_left   = g - 1;
          out_ready_i <= 1'b0;
        end
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("cycle limit reached with %0d status words outstanding", pending_status.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    valve_cfg    = '{10'd900, 10'd50, 10'd30, 10'd980, 16'd1000};
    m_mode       = ModeRecover;
    m_valve      = 1'b0;
    m_manual     = 1'b0;
    m_switch_led = 1'b0;
    m_pattern    = PatLevel;
    m_hand_base  = '0;
    m_hand_polls = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++)
      offer_word(DirRows[i].word, DirRows[i].typed, DirRows[i].want);
    in_valid_i <= 1'b0;
    drain();

    for (int unsigned p = 0; p < NumPasses; p++) begin
      load_settings(pass_settings(p));
      for (int unsigned n = 0; n < WordsPerPass; n++) begin
        calm_stretch = (n >= 100 && n < 160);
        if (p == 2 && n == 20) long_hold_req = 1'b1;
        offer_word(pick_word(), 1'b0, NoCheck);
      end
      calm_stretch = 1'b0;
      in_valid_i <= 1'b0;
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (fault_count == 0 && pending_status.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/tovc_pkg.sv
rtl/core/tovc_cfg_regs.sv
rtl/core/tovc_fsm.sv
rtl/core/tank_overflow_valve_controller.sv
tb/sv/tank_overflow_valve_controller_tb.sv
